// File: hdl/utt_pkg.sv
package utt_pkg;

  typedef enum logic [1:0] {
    FORM_RAW   = 2'd0,
    FORM_UTF8  = 2'd1,
    FORM_UTF16 = 2'd2,
    FORM_UTF32 = 2'd3
  } form_t;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_RANGE     = 2'd1;
  localparam logic [1:0] ERR_SURROGATE = 2'd2;

  localparam logic [20:0] MAX_POINT  = 21'h10FFFF;
  localparam logic [20:0] SURR_LO    = 21'h00D800;
  localparam logic [20:0] SURR_HI    = 21'h00DFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h010000;
  localparam logic [15:0] HI_SURR    = 16'hD800;
  localparam logic [15:0] LO_SURR    = 16'hDC00;
  localparam logic [7:0]  SPACE_BYTE = 8'h20;

  // One decoded point (or one raw byte) waiting for the encoder.
  typedef struct packed {
    form_t       form;
    logic [20:0] cp;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: hdl/utt_front.sv
module utt_front (
  input  logic           clk,
  input  logic           rst_n,
  input  utt_pkg::form_t form,
  input  logic           in_valid,
  input  logic [7:0]     in_byte,
  output logic           in_stall,
  input  utt_pkg::q_stat_t q_stat,
  output logic           push,
  output utt_pkg::entry_t push_entry
);
  import utt_pkg::*;

  logic [20:0] partial_r, partial_nxt;
  logic [1:0]  left_r, left_nxt;
  logic        accept;
  logic [20:0] gathered;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign gathered = {partial_r[14:0], in_byte[5:0]};

  always_comb begin
    partial_nxt     = partial_r;
    left_nxt        = left_r;
    push            = 1'b0;
    push_entry.form = form;
    push_entry.cp   = {13'd0, in_byte};
    if (accept) begin
      if (form == FORM_RAW) begin
        // raw bytes abandon any open sequence
        partial_nxt = '0;
        left_nxt    = '0;
        push        = 1'b1;
      end else if (left_r != 2'd0) begin
        partial_nxt   = gathered;
        left_nxt      = left_r - 2'd1;
        push_entry.cp = gathered;
        push          = (left_r == 2'd1);
      end else if (in_byte == SPACE_BYTE) begin
        push = 1'b0;
      end else if (in_byte[7] == 1'b0) begin
        push = 1'b1;
      end else if (in_byte[7:5] == 3'b110) begin
        partial_nxt = {16'd0, in_byte[4:0]};
        left_nxt    = 2'd1;
      end else if (in_byte[7:4] == 4'b1110) begin
        partial_nxt = {17'd0, in_byte[3:0]};
        left_nxt    = 2'd2;
      end else if (in_byte[7:3] == 5'b11110) begin
        partial_nxt = {18'd0, in_byte[2:0]};
        left_nxt    = 2'd3;
      end else begin
        // invalid lead stands for itself
        push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      left_r    <= '0;
    end else begin
      partial_r <= partial_nxt;
      left_r    <= left_nxt;
    end
  end

endmodule

// File: hdl/utt_queue.sv
module utt_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  utt_pkg::entry_t  push_entry,
  input  logic             pop,
  output utt_pkg::entry_t  head,
  output utt_pkg::q_stat_t q_stat
);
  import utt_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  entry_t        slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign q_stat.full  = (count_r == FULL_CNT);
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    if (do_push && !do_pop)      count_nxt = count_r + CW'(1);
    else if (!do_push && do_pop) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) slots_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT) else $error("queue count beyond depth");
  a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full) else $error("push into full queue");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("queue count did not advance on push");

endmodule

// File: hdl/utt_back.sv
module utt_back (
  input  logic            clk,
  input  logic            rst_n,
  input  utt_pkg::entry_t head,
  input  utt_pkg::q_stat_t q_stat,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [20:0]     out_code_unit,
  output logic            out_last_unit,
  output logic [1:0]      out_error
);
  import utt_pkg::*;

  logic [1:0]  idx_r, idx_nxt;
  logic        valid_r, valid_nxt;
  logic [20:0] unit_r, unit_nxt;
  logic        last_r, last_nxt;
  logic [1:0]  err_r, err_nxt;

  logic        advance;
  logic [20:0] cp;
  logic [19:0] v;
  logic [1:0]  n_units;
  logic [7:0]  u8 [4];
  logic [20:0] unit_sel;
  logic        last_sel;
  logic [1:0]  err_sel;

  assign cp      = head.cp;
  assign v       = 20'(cp - SUPP_BASE);
  assign advance = !q_stat.empty && (!valid_r || !out_stall);

  // encoder: unit number idx_r of the head entry
  always_comb begin
    u8[0]   = cp[7:0];
    u8[1]   = 8'd0;
    u8[2]   = 8'd0;
    u8[3]   = 8'd0;
    n_units = 2'd0;
    if (cp <= 21'h7F) begin
      n_units = 2'd0;
    end else if (cp <= 21'h7FF) begin
      n_units = 2'd1;
      u8[0]   = {3'b110, cp[10:6]};
      u8[1]   = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      n_units = 2'd2;
      u8[0]   = {4'b1110, cp[15:12]};
      u8[1]   = {2'b10, cp[11:6]};
      u8[2]   = {2'b10, cp[5:0]};
    end else begin
      n_units = 2'd3;
      u8[0]   = {5'b11110, cp[20:18]};
      u8[1]   = {2'b10, cp[17:12]};
      u8[2]   = {2'b10, cp[11:6]};
      u8[3]   = {2'b10, cp[5:0]};
    end

    unit_sel = cp;
    last_sel = 1'b1;
    err_sel  = ERR_NONE;
    if (head.form == FORM_RAW) begin
      unit_sel = cp;
    end else if (cp > MAX_POINT) begin
      err_sel = ERR_RANGE;
    end else begin
      unique case (head.form)
        FORM_UTF8: begin
          unit_sel = {13'd0, u8[idx_r]};
          last_sel = (idx_r == n_units);
        end
        FORM_UTF16: begin
          if (cp <= 21'hFFFF) begin
            if (cp >= SURR_LO && cp <= SURR_HI) err_sel = ERR_SURROGATE;
          end else if (idx_r == 2'd0) begin
            unit_sel = {5'd0, HI_SURR + {6'd0, v[19:10]}};
            last_sel = 1'b0;
          end else begin
            unit_sel = {5'd0, LO_SURR + {6'd0, v[9:0]}};
          end
        end
        default: unit_sel = cp;
      endcase
    end
  end

  assign pop = advance && last_sel;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r && out_stall;
    unit_nxt  = unit_r;
    last_nxt  = last_r;
    err_nxt   = err_r;
    if (advance) begin
      valid_nxt = 1'b1;
      unit_nxt  = unit_sel;
      last_nxt  = last_sel;
      err_nxt   = err_sel;
      idx_nxt   = last_sel ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unit_r <= unit_nxt;
    last_r <= last_nxt;
    err_r  <= err_nxt;
  end

  assign out_valid     = valid_r;
  assign out_code_unit = unit_r;
  assign out_last_unit = last_r;
  assign out_error     = err_r;

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && err_r != ERR_NONE) |-> last_r) else $error("error beat not last");
  a_idx_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != 2'd0) |-> !q_stat.empty) else $error("unit index without entry");
  a_pop_resets_idx: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (idx_r == 2'd0)) else $error("unit index kept after pop");

endmodule

// File: hdl/utf8_to_utf_transcoder.sv
// UTF-8 stream transcoder to raw byte codes, UTF-8, UTF-16 or UTF-32 units.
// Input channel: in_valid / in_stall with in_byte; a byte is taken at an edge
// with in_valid high and in_stall low. One byte per cycle is accepted while
// the internal queue has room.
// Output channel: out_valid / out_stall with out_code_unit, out_last_unit and
// out_error. A code point leaves as one to four beats, one beat per cycle while
// out_stall is low; the last beat of a character, every raw beat and every
// error beat carries out_last_unit. A point's closing byte is written into the
// queue; the encoder then loads its first beat into the output register behind
// out_valid. It emits one unit per cycle while out_stall is low, so sustained
// rate is one byte per cycle when the stream averages one unit per byte or less.
// Configuration: cfg_valid / cfg_ready with cfg_data sets the output form
// (0 raw, 1 UTF-8, 2 UTF-16, 3 UTF-32); write it only while the block is idle.
// Reset (rst_n low, synchronous) selects UTF-8, closes any open sequence and
// empties the queue and the output register.
// When the receiver stalls, the output beat holds; the queue fills, and once
// it is full in_stall rises until the encoder drains an entry.
module utf8_to_utf_transcoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [20:0] out_code_unit,
  output logic        out_last_unit,
  output logic [1:0]  out_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data
);
  import utt_pkg::*;

  form_t   form_r, form_nxt;
  logic    push, pop;
  entry_t  push_entry, head;
  q_stat_t q_stat;

  assign cfg_ready = 1'b1;

  always_comb begin
    form_nxt = form_r;
    if (cfg_valid && cfg_ready) form_nxt = form_t'(cfg_data);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) form_r <= FORM_UTF8;
    else        form_r <= form_nxt;
  end

  utt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .form       (form_r),
    .in_valid   (in_valid),
    .in_byte    (in_byte),
    .in_stall   (in_stall),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  utt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  utt_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .q_stat        (q_stat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_code_unit (out_code_unit),
    .out_last_unit (out_last_unit),
    .out_error     (out_error)
  );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import utt_pkg::*;

  localparam int DRAIN_CYCLES = 16;
  localparam int PHASES       = 9;

  typedef struct packed {
    logic [20:0] code_unit;
    logic        last_unit;
    logic [1:0]  error;
  } unit_beat_t;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte       = 8'h00;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [20:0] out_code_unit;
  logic        out_last_unit;
  logic [1:0]  out_error;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data      = FORM_UTF8;

  logic [7:0]  pending_bytes[$];
  unit_beat_t  expected_units[$];
  int          mismatches    = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  // Decoder state as seen from outside
  form_t       model_form    = FORM_UTF8;
  logic [20:0] gather_point  = '0;
  logic [1:0]  bytes_owed    = '0;

  form_t phase_form [PHASES] = '{FORM_UTF8, FORM_UTF16, FORM_RAW, FORM_UTF32, FORM_UTF8,
                                 FORM_UTF16, FORM_UTF32, FORM_RAW, FORM_UTF8};
  int    phase_len  [PHASES] = '{50, 50, 45, 50, 55, 55, 55, 35, 40};

  utf8_to_utf_transcoder uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_code_unit (out_code_unit),
    .out_last_unit (out_last_unit),
    .out_error     (out_error),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void push_unit(logic [20:0] u, logic l, logic [1:0] e);
    unit_beat_t t;
    t.code_unit = u;
    t.last_unit = l;
    t.error     = e;
    expected_units = {expected_units, t};
  endfunction

  function automatic void encode_point(logic [20:0] cp);
    logic [20:0] v;
    if (cp > MAX_POINT) begin
      push_unit(cp, 1'b1, ERR_RANGE);
      return;
    end
    case (model_form)
      FORM_UTF8: begin
        if (cp <= 21'h7F) begin
          push_unit(cp, 1'b1, ERR_NONE);
        end else if (cp <= 21'h7FF) begin
          push_unit({13'd0, 3'b110, cp[10:6]}, 1'b0, ERR_NONE);
          push_unit({13'd0, 2'b10, cp[5:0]}, 1'b1, ERR_NONE);
        end else if (cp <= 21'hFFFF) begin
          push_unit({13'd0, 4'b1110, cp[15:12]}, 1'b0, ERR_NONE);
          push_unit({13'd0, 2'b10, cp[11:6]}, 1'b0, ERR_NONE);
          push_unit({13'd0, 2'b10, cp[5:0]}, 1'b1, ERR_NONE);
        end else begin
          push_unit({13'd0, 5'b11110, cp[20:18]}, 1'b0, ERR_NONE);
          push_unit({13'd0, 2'b10, cp[17:12]}, 1'b0, ERR_NONE);
          push_unit({13'd0, 2'b10, cp[11:6]}, 1'b0, ERR_NONE);
          push_unit({13'd0, 2'b10, cp[5:0]}, 1'b1, ERR_NONE);
        end
      end
      FORM_UTF16: begin
        if (cp < SUPP_BASE) begin
          if (cp >= SURR_LO && cp <= SURR_HI) push_unit(cp, 1'b1, ERR_SURROGATE);
          else push_unit(cp, 1'b1, ERR_NONE);
        end else begin
          v = cp - SUPP_BASE;
          push_unit(21'(HI_SURR) + 21'(v[19:10]), 1'b0, ERR_NONE);
          push_unit(21'(LO_SURR) + 21'(v[9:0]), 1'b1, ERR_NONE);
        end
      end
      default: push_unit(cp, 1'b1, ERR_NONE);
    endcase
  endfunction

  function automatic void transcode_byte(logic [7:0] b);
    if (model_form == FORM_RAW) begin
      // raw beats also drop any open sequence
      bytes_owed   = '0;
      gather_point = '0;
      push_unit(21'(b), 1'b1, ERR_NONE);
    end else if (bytes_owed != 0) begin
      gather_point = {gather_point[14:0], b[5:0]};
      bytes_owed   = bytes_owed - 2'd1;
      if (bytes_owed == 0) encode_point(gather_point);
    end else if (b == SPACE_BYTE) begin
      // skip space at sequence start
    end else if (b < 8'h80) begin
      encode_point(21'(b));
    end else if (b[7:5] == 3'b110) begin
      gather_point = 21'(b[4:0]);
      bytes_owed   = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      gather_point = 21'(b[3:0]);
      bytes_owed   = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      gather_point = 21'(b[2:0]);
      bytes_owed   = 2'd3;
    end else begin
      encode_point(21'(b));
    end
  endfunction

  // Queue the n low-order bytes of word, most significant first
  function automatic void queue_bytes(logic [31:0] word, int n);
    for (int i = n - 1; i >= 0; i--) pending_bytes = {pending_bytes, word[8*i +: 8]};
  endfunction

  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 4) == 0) return 8'($urandom);
    return {2'b10, 6'($urandom)};
  endfunction

  // Queue one random character, mostly well formed; return bytes queued
  function automatic int queue_random_char();
    int r;
    int len;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      pending_bytes = {pending_bytes, 8'($urandom)};
      return 1;
    end
    if (r < 22) begin
      pending_bytes = {pending_bytes, SPACE_BYTE};
      return 1;
    end
    if (r < 40) begin
      pending_bytes = {pending_bytes, {1'b0, 7'($urandom)}};
      return 1;
    end
    if (r < 57) begin
      pending_bytes = {pending_bytes, {3'b110, 5'($urandom)}};
      len = 1;
    end else if (r < 74) begin
      pending_bytes = {pending_bytes, {4'b1110, 4'($urandom)}};
      len = 2;
    end else if (r < 92) begin
      pending_bytes = {pending_bytes, {5'b11110, 3'($urandom)}};
      len = 3;
    end else begin
      // truncated sequence: the next lead gets eaten as continuation
      pending_bytes = {pending_bytes, {5'b11110, 3'($urandom)}};
      len = $urandom_range(0, 2);
    end
    for (int i = 0; i < len; i++) pending_bytes = {pending_bytes, cont_byte()};
    return len + 1;
  endfunction

  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_units.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_form(form_t f);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= f;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    model_form = f;
  endtask

  // Sender: hold a stalled beat, otherwise advance or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) transcode_byte(in_byte);
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_byte  <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each accepted beat against the oldest expected unit
  always @(posedge clk) begin
    unit_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_units.size() == 0) begin
        $display("%0t unexpected beat: unit %h last %b err %0d", $time,
                 out_code_unit, out_last_unit, out_error);
        mismatches++;
      end else begin
        want = expected_units.pop_front();
        if (want.code_unit != out_code_unit || want.last_unit != out_last_unit ||
            want.error != out_error) begin
          $display("%0t mismatch: expected unit %h last %b err %0d, got unit %h last %b err %0d",
                   $time, want.code_unit, want.last_unit, want.error,
                   out_code_unit, out_last_unit, out_error);
          mismatches++;
        end
      end
    end
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
  end

  initial begin
    int added;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        wait_quiet();
        write_form(phase_form[p]);
        @(negedge clk);
      end
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      case (p)
        0: begin
          queue_bytes(32'h007F20, 3);
          queue_bytes(32'hC2A9, 2);
          queue_bytes(32'hE282AC, 3);
          queue_bytes(32'hF09F9880, 4);
          queue_bytes(32'h80FF, 2);
          queue_bytes(32'hC120, 2);       // space as continuation
          queue_bytes(32'hF7BFBFBF, 4);   // beyond the top code point
        end
        1: begin
          pending_bytes = {pending_bytes, 8'hAC}; // closes the sequence opened under UTF-8
          queue_bytes(32'hEDA080, 3);
          queue_bytes(32'hF48FBFBF, 4);
        end
        2: queue_bytes(32'h20FF00, 3);
        default: ;
      endcase
      added = 0;
      while (added < phase_len[p]) added += queue_random_char();
      // leave a sequence open across the next form change
      if (p == 0) queue_bytes(32'hE282, 2);
      if (p == 1) queue_bytes(32'hF09F, 2);
    end
    wait_quiet();
    if (mismatches == 0 && expected_units.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
